// ===== sv/process_ready_table_defines.svh =====
// Assertion macros for the process ready table RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef PROCESS_READY_TABLE_DEFINES_SVH
`define PROCESS_READY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset
`define PRT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("process_ready_table: assertion failed");

// Checked on every rising edge, reset included
`define PRT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("process_ready_table: assertion failed");

`else

`define PRT_ASSERT(label, clk, rst, prop)
`define PRT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== sv/prt_pkg.sv =====
// Shared types and command codes for the process ready table.
// No dependencies; used by the slot RAM and the top level.
package prt_pkg;

   // Command codes carried on req_kind
   localparam logic [2:0] KIND_ADD      = 3'd0;
   localparam logic [2:0] KIND_REMOVE   = 3'd1;
   localparam logic [2:0] KIND_CONTAINS = 3'd2;
   localparam logic [2:0] KIND_REWIND   = 3'd3;
   localparam logic [2:0] KIND_NEXT     = 3'd4;

   localparam int PID_W  = 32;
   localparam int PRIO_W = 8;

   // One stored slot: process id and priority
   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [PRIO_W-1:0] prio;
   } slot_entry_type;

endpackage

// ===== sv/process_ready_table.sv =====
// Process ready table: SLOTS slots of {valid, pid, priority}; each command beat
// yields one response beat that also carries the best (most urgent) entry.
// Depends on prt_pkg, prt_slot_ram and process_ready_table_defines.svh.
//
// Each command goes from accept to response in these steps: one sweep of the
// slot RAM read port over all slots (one slot per cycle, registered read data),
// a step to close the sweep, then a step to write back an added entry and
// register the response. A new command is accepted while a response
// beat still waits; it finishes only once that beat has been taken. Valid bits
// live in flip-flops cleared by reset; ids and priorities live in the RAM and
// are only used for slots whose valid bit is set, so no clearing pass is needed.
module process_ready_table #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_pid,
   input  logic [7:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_out_pid,
   output logic [7:0]  rsp_out_priority,
   output logic        rsp_best_valid,
   output logic [31:0] rsp_best_pid,
   output logic [7:0]  rsp_best_priority
);

`include "process_ready_table_defines.svh"

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CUR_W = IDX_W + 1;
   localparam logic [CUR_W-1:0] SLOTS_C = CUR_W'(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // Command under work
   logic [2:0]  op_kind_ff;
   logic [31:0] op_pid_ff;
   logic [7:0]  op_prio_ff;

   // Slot state
   logic [SLOTS-1:0] valid_ff;
   logic [CUR_W-1:0] cursor_ff;

   // Sweep control
   logic [CUR_W-1:0] iss_ff;
   logic             chk_vld_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   // Sweep accumulators
   logic             free_got_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             found_ff;
   logic [31:0]      nxt_pid_ff;
   logic [7:0]       nxt_prio_ff;
   logic [IDX_W-1:0] nxt_idx_ff;
   logic             bv_ff;
   logic [31:0]      bpid_ff;
   logic [7:0]       bprio_ff;
   logic [IDX_W-1:0] bidx_ff;

   // Response register
   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   logic        rsp_found_ff;
   logic [31:0] rsp_out_pid_ff;
   logic [7:0]  rsp_out_prio_ff;
   logic        rsp_bv_ff;
   logic [31:0] rsp_bpid_ff;
   logic [7:0]  rsp_bprio_ff;

   prt_pkg::slot_entry_type rd_data;
   prt_pkg::slot_entry_type wr_data;

   logic             req_take;
   logic             rd_en;
   logic             is_add;
   logic             is_rem;
   logic             is_cont;
   logic             is_next;
   logic             slot_v;
   logic             match;
   logic             clr;
   logic             live;
   logic             fin_go;
   logic             add_ok;
   logic             new_wins;
   logic             wr_en;
   logic             rsp_stall;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign is_add  = (op_kind_ff == prt_pkg::KIND_ADD);
   assign is_rem  = (op_kind_ff == prt_pkg::KIND_REMOVE);
   assign is_cont = (op_kind_ff == prt_pkg::KIND_CONTAINS);
   assign is_next = (op_kind_ff == prt_pkg::KIND_NEXT);

   // Read one slot per cycle during the sweep
   assign rd_en = (state_ff == ST_SCAN) && (iss_ff < SLOTS_C);

   // Per-slot evaluation of the returning read data
   always_comb begin
      slot_v = valid_ff[chk_idx_ff];
      match  = slot_v && (rd_data.pid == op_pid_ff);
      clr    = match && (is_add || is_rem);
      live   = slot_v && !clr;
   end

   // Finish step: response slot must be free
   assign fin_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign add_ok    = is_add && free_got_ff;
   assign rsp_stall = rsp_valid_ff && !rsp_ready;

   // Added entry versus best surviving entry; lower slot wins ties
   assign new_wins = !bv_ff || (op_prio_ff < bprio_ff) ||
                     ((op_prio_ff == bprio_ff) && (free_idx_ff < bidx_ff));

   assign wr_en        = fin_go && add_ok;
   assign wr_data.pid  = op_pid_ff;
   assign wr_data.prio = op_prio_ff;

   prt_slot_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Sequencer, slot state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         cursor_ff    <= '0;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Response beat taken with no new beat behind it
         if (rsp_valid_ff && rsp_ready && !fin_go) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  op_kind_ff  <= req_kind;
                  op_pid_ff   <= req_pid;
                  op_prio_ff  <= req_priority_req;
                  iss_ff      <= '0;
                  chk_vld_ff  <= 1'b0;
                  free_got_ff <= 1'b0;
                  found_ff    <= 1'b0;
                  nxt_pid_ff  <= '0;
                  nxt_prio_ff <= '0;
                  bv_ff       <= 1'b0;
                  bpid_ff     <= '0;
                  bprio_ff    <= '0;
                  state_ff    <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               // Issue side
               chk_vld_ff <= rd_en;
               chk_idx_ff <= iss_ff[IDX_W-1:0];
               if (rd_en) begin
                  iss_ff <= iss_ff + CUR_W'(1);
               end

               // Check side: slot chk_idx_ff has its data on rd_data
               if (chk_vld_ff) begin
                  if (clr) begin
                     valid_ff[chk_idx_ff] <= 1'b0;
                  end
                  if (is_add && !live && !free_got_ff) begin
                     free_got_ff <= 1'b1;
                     free_idx_ff <= chk_idx_ff;
                  end
                  if (is_cont && match) begin
                     found_ff <= 1'b1;
                  end
                  if (is_next && slot_v && !found_ff &&
                      ({1'b0, chk_idx_ff} >= cursor_ff)) begin
                     found_ff    <= 1'b1;
                     nxt_pid_ff  <= rd_data.pid;
                     nxt_prio_ff <= rd_data.prio;
                     nxt_idx_ff  <= chk_idx_ff;
                  end
                  if (live && (!bv_ff || (rd_data.prio < bprio_ff))) begin
                     bv_ff    <= 1'b1;
                     bpid_ff  <= rd_data.pid;
                     bprio_ff <= rd_data.prio;
                     bidx_ff  <= chk_idx_ff;
                  end
               end else if (iss_ff == SLOTS_C) begin
                  state_ff <= ST_FINISH;
               end
            end

            ST_FINISH: begin
               if (fin_go) begin
                  if (add_ok) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                  end
                  if (op_kind_ff == prt_pkg::KIND_REWIND) begin
                     cursor_ff <= '0;
                  end else if (is_next) begin
                     cursor_ff <= found_ff ? ({1'b0, nxt_idx_ff} + CUR_W'(1)) : SLOTS_C;
                  end

                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= is_add && !free_got_ff;
                  rsp_found_ff    <= found_ff;
                  rsp_out_pid_ff  <= nxt_pid_ff;
                  rsp_out_prio_ff <= nxt_prio_ff;
                  if (add_ok && new_wins) begin
                     rsp_bv_ff    <= 1'b1;
                     rsp_bpid_ff  <= op_pid_ff;
                     rsp_bprio_ff <= op_prio_ff;
                  end else begin
                     rsp_bv_ff    <= bv_ff;
                     rsp_bpid_ff  <= bpid_ff;
                     rsp_bprio_ff <= bprio_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_out_pid       = rsp_out_pid_ff;
   assign rsp_out_priority  = rsp_out_prio_ff;
   assign rsp_best_valid    = rsp_bv_ff;
   assign rsp_best_pid      = rsp_bpid_ff;
   assign rsp_best_priority = rsp_bprio_ff;

   // Assertions
   `PRT_ASSERT_ALWAYS(a_cursor_range, clock, reset || (cursor_ff <= SLOTS_C))
   `PRT_ASSERT(a_free_sticky, clock, reset, (state_ff == ST_SCAN && free_got_ff) |=> free_got_ff)
   `PRT_ASSERT(a_add_has_best, clock, reset, (fin_go && add_ok) |=> rsp_best_valid)
   `PRT_ASSERT(a_full_has_best, clock, reset, (rsp_valid && rsp_status) |-> rsp_best_valid)
   `PRT_ASSERT(a_fin_hold, clock, reset, (rsp_stall && state_ff == ST_FINISH) |=> state_ff == ST_FINISH)

endmodule

// ===== sv/prt_slot_ram.sv =====
// Slot payload memory: one write port, one read port, registered read data.
// Depends on prt_pkg for the entry type.
module prt_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  prt_pkg::slot_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output prt_pkg::slot_entry_type rd_data
);

   prt_pkg::slot_entry_type mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
